FILE: rtl/dips_pkg.sv
// shared types and constants of the discrete input packet supervisor
package dips_pkg;

	localparam int NUM_LANES = 8;
	localparam logic [7:0] MIN_LEN = 8'd21;
	localparam logic [3:0] TYPE_OK = 4'h2;

	// configuration register indexes
	localparam logic [2:0] CFG_ENABLE = 3'd0;
	localparam logic [2:0] CFG_SETTLE = 3'd1;
	localparam logic [2:0] CFG_RESP_TO = 3'd2;
	localparam logic [2:0] CFG_ERR_TO = 3'd3;
	localparam logic [2:0] CFG_POLL = 3'd4;

	typedef enum logic [2:0] {
		EV_REPORT = 3'd0,
		EV_POLL = 3'd1,
		EV_RAISED = 3'd2,
		EV_CLEARED = 3'd3,
		EV_REJECT = 3'd4
	} ev_kind_t;

	typedef enum logic [1:0] {
		MODE_STEP = 2'd0,
		MODE_WAIT = 2'd1,
		MODE_TIMEOUT = 2'd2,
		MODE_ERROR = 2'd3
	} mode_t;

	typedef struct packed {
		logic action;
		logic [7:0] packet_length;
		logic [3:0] type_nibble;
		logic [63:0] first_half;
		logic [63:0] second_half;
	} in_item_t;

	typedef struct packed {
		ev_kind_t event_kind;
		logic [2:0] byte_index;
		logic [7:0] byte_value;
		logic error_flag;
		logic last;
	} out_item_t;

	// results of one request handed from control to the emitter
	typedef struct packed {
		logic head_valid;
		ev_kind_t head_kind;
		logic [NUM_LANES-1:0] diff;
		logic [63:0] bytes;
		logic error_flag;
	} job_t;

endpackage

FILE: rtl/dips_lane.sv
// one byte lane: point masking, overlap check and change detection
module dips_lane #(
	parameter int LANE = 0,
	parameter int POINT_COUNT = 64
) (
	input  logic [7:0] first_byte,
	input  logic [7:0] cand_byte,
	input  logic [7:0] rep_byte,
	output logic [7:0] masked_byte,
	output logic       overlap,
	output logic       differ
);
	// points of this lane that exist
	localparam int NV_RAW = POINT_COUNT - 8 * LANE;
	localparam int NV = (NV_RAW < 0) ? 0 : ((NV_RAW > 8) ? 8 : NV_RAW);
	localparam logic [7:0] LANE_MASK = ~(8'hFF >> NV);

	// mask, overlap and compare against last report
	assign masked_byte = cand_byte & LANE_MASK;
	assign overlap = |(first_byte & cand_byte & LANE_MASK);
	assign differ = (masked_byte != rep_byte);
endmodule

FILE: rtl/dips_ctrl.sv
// supervisor control: registers, mode, tick counters and lane merge
module dips_ctrl #(
	parameter int POINT_COUNT = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dips_pkg::in_item_t item,
	input  logic              item_fire,
	input  logic              cfg_valid,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output dips_pkg::job_t    job
);
	import dips_pkg::*;

	logic enable_q;
	logic [15:0] settle_q, resp_to_q, err_to_q, poll_q;
	mode_t mode_q, mode_d;
	logic err_q, err_d;
	logic [63:0] pending_q, pending_d, reported_q, reported_d;
	logic [15:0] si_q, si_d, st_q, st_d, sp_q, sp_d;
	logic [15:0] si_b, st_b, sp_b;

	logic [63:0] cand, masked;
	logic [NUM_LANES-1:0] lane_ovl, lane_diff;
	logic rep;
	logic head_valid;
	ev_kind_t head_kind;

	// candidate states: new packet or stored pending states
	assign cand = item.action ? pending_q : item.second_half;

	// byte lanes, byte 0 in the top bits
	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		dips_lane #(.LANE(l), .POINT_COUNT(POINT_COUNT)) u_lane (
			.first_byte (item.first_half[63-8*l -: 8]),
			.cand_byte  (cand[63-8*l -: 8]),
			.rep_byte   (reported_q[63-8*l -: 8]),
			.masked_byte(masked[63-8*l -: 8]),
			.overlap    (lane_ovl[l]),
			.differ     (lane_diff[l])
		);
	end

	// saturating tick counters
	assign si_b = (si_q == 16'hFFFF) ? si_q : si_q + 16'd1;
	assign st_b = (st_q == 16'hFFFF) ? st_q : st_q + 16'd1;
	assign sp_b = (sp_q == 16'hFFFF) ? sp_q : sp_q + 16'd1;

	// next state and events of one request
	always_comb begin
		mode_d = mode_q;
		err_d = err_q;
		pending_d = pending_q;
		reported_d = reported_q;
		si_d = si_q;
		st_d = st_q;
		sp_d = sp_q;
		rep = 1'b0;
		head_valid = 1'b0;
		head_kind = EV_REJECT;
		if (!item.action) begin
			if (item.packet_length >= MIN_LEN && enable_q) begin
				if (item.type_nibble != TYPE_OK) begin
					head_valid = 1'b1;
				end else begin
					si_d = 16'd0;
					if (|lane_ovl) begin
						mode_d = MODE_ERROR;
						head_valid = 1'b1;
					end else if (mode_q == MODE_ERROR) begin
						if (err_q) begin
							err_d = 1'b0;
							head_valid = 1'b1;
							head_kind = EV_CLEARED;
						end
						mode_d = MODE_STEP;
						pending_d = masked;
						rep = 1'b1;
					end else if (mode_q == MODE_WAIT) begin
						pending_d = masked;
					end else begin
						pending_d = masked;
						if (settle_q == 16'd0) begin
							rep = 1'b1;
						end else begin
							mode_d = MODE_WAIT;
						end
					end
				end
			end
		end else if (enable_q) begin
			si_d = si_b;
			st_d = st_b;
			sp_d = sp_b;
			case (mode_q)
				MODE_STEP: begin
					if (si_b >= resp_to_q) begin
						mode_d = MODE_TIMEOUT;
						st_d = 16'd0;
						sp_d = 16'd0;
					end
				end
				MODE_WAIT: begin
					if (si_b >= settle_q) begin
						si_d = 16'd0;
						mode_d = MODE_STEP;
						rep = 1'b1;
					end
				end
				MODE_TIMEOUT: begin
					if (st_b >= err_to_q) begin
						mode_d = MODE_ERROR;
						st_d = 16'd0;
						if (!err_q) begin
							err_d = 1'b1;
							head_valid = 1'b1;
							head_kind = EV_RAISED;
						end
					end else if (sp_b >= poll_q) begin
						sp_d = 16'd0;
						head_valid = 1'b1;
						head_kind = EV_POLL;
					end
				end
				default: begin
					if (st_b >= poll_q) begin
						st_d = 16'd0;
						head_valid = 1'b1;
						head_kind = EV_POLL;
					end
				end
			endcase
		end
		// every changed byte is reported, so reported catches up fully
		if (rep) begin
			reported_d = masked;
		end
	end

	// merge of lane findings into the job
	always_comb begin
		job.head_valid = head_valid;
		job.head_kind = head_kind;
		job.diff = rep ? lane_diff : '0;
		job.bytes = masked;
		job.error_flag = err_d;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			settle_q <= 16'd0;
			resp_to_q <= 16'd10;
			err_to_q <= 16'd30;
			poll_q <= 16'd5;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ENABLE: enable_q <= cfg_data[0];
				CFG_SETTLE: settle_q <= cfg_data;
				CFG_RESP_TO: resp_to_q <= cfg_data;
				CFG_ERR_TO: err_to_q <= cfg_data;
				CFG_POLL: poll_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// supervisor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ERROR;
			err_q <= 1'b1;
			pending_q <= '0;
			reported_q <= '0;
			si_q <= '0;
			st_q <= '0;
			sp_q <= '0;
		end else if (item_fire) begin
			mode_q <= mode_d;
			err_q <= err_d;
			pending_q <= pending_d;
			reported_q <= reported_d;
			si_q <= si_d;
			st_q <= st_d;
			sp_q <= sp_d;
		end
	end
endmodule

FILE: rtl/dips_emit.sv
// result sequencer: held job results, one per ready cycle
module dips_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  dips_pkg::job_t     job,
	input  logic               load,
	output logic               can_load,
	output logic               result_valid,
	input  logic               result_ready,
	output dips_pkg::out_item_t result
);
	import dips_pkg::*;

	logic head_q;
	ev_kind_t kind_q;
	logic [NUM_LANES-1:0] mask_q, mask_pop;
	logic [63:0] bytes_q;
	logic err_q;
	logic [2:0] sel_idx;
	logic busy, last, pop;

	// lowest pending byte index goes first
	always_comb begin
		sel_idx = 3'd0;
		for (int i = NUM_LANES - 1; i >= 0; i--) begin
			if (mask_q[i]) sel_idx = 3'(i);
		end
	end

	assign mask_pop = mask_q & ~(8'b1 << sel_idx);
	assign busy = head_q || (|mask_q);
	assign last = head_q ? (mask_q == '0) : (mask_pop == '0);
	assign pop = busy && result_ready;
	assign can_load = !busy || (result_ready && last);
	assign result_valid = busy;

	// result fields
	always_comb begin
		result.event_kind = head_q ? kind_q : EV_REPORT;
		result.byte_index = head_q ? 3'd0 : sel_idx;
		result.byte_value = head_q ? 8'd0 : bytes_q[{3'd7 - sel_idx, 3'b000} +: 8];
		result.error_flag = err_q;
		result.last = last;
	end

	// job control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= 1'b0;
			mask_q <= '0;
		end else if (load) begin
			head_q <= job.head_valid;
			mask_q <= job.diff;
		end else if (pop) begin
			if (head_q) begin
				head_q <= 1'b0;
			end else begin
				mask_q <= mask_pop;
			end
		end
	end

	// job payload
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= job.head_kind;
			bytes_q <= job.bytes;
			err_q <= job.error_flag;
		end
	end
endmodule

FILE: rtl/discrete_input_packet_supervisor.sv
// top level of the discrete input packet supervisor
//
// channel   signals                              direction  content
// item      item_valid item_ready item           in         packet or tick
// result    result_valid result_ready result     out        events and byte reports
// cfg       cfg_valid cfg_ready cfg_index cfg_data  in      register writes
//
// a request's state update and lane compare finish in the cycle it is taken
// results leave the emitter one per cycle unless stalled, up to nine per request
// the next request is taken in the cycle the last result of the previous one leaves
// a stalled result holds the emitter; requests without results pass when it is free
// reset is asynchronous, active low; cfg_ready is always high
module discrete_input_packet_supervisor #(
	parameter int POINT_COUNT = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  dips_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output dips_pkg::out_item_t result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import dips_pkg::*;

	job_t job;
	logic item_fire;
	logic can_load;

	assign cfg_ready = 1'b1;
	assign item_ready = can_load;
	assign item_fire = item_valid && can_load;

	// control and lanes
	dips_ctrl #(.POINT_COUNT(POINT_COUNT)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.item_fire(item_fire),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.job      (job)
	);

	// result sequencer
	dips_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.job         (job),
		.load        (item_fire),
		.can_load    (can_load),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);
endmodule

FILE: rtl/dips_checker.sv
// port level checks of the supervisor and their binding
module dips_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_ready,
	input logic                result_valid,
	input logic                result_ready,
	input dips_pkg::out_item_t result
);
	import dips_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// a new request only while the last result of the previous one leaves
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && result_valid |-> result_ready && result.last)
		else $error("request taken while results pending");

	// non report events carry no byte
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.event_kind != EV_REPORT
		|-> result.byte_index == 3'd0 && result.byte_value == 8'd0)
		else $error("event carries byte data");

	// results of one request follow without gap and share the flag
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !result.last
		|=> result_valid && result.error_flag == $past(result.error_flag))
		else $error("broken result burst");
endmodule

bind discrete_input_packet_supervisor dips_checker u_dips_checker (.*);
